// File: rtl/sts_pkg.sv
// Shared types, codes and character helpers for the smalltalk token scanner.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int MaxResults          = 6;
  localparam int CountBits           = 3;

  // token kinds
  localparam logic [4:0] K_EOF       = 5'd0;
  localparam logic [4:0] K_IDENT     = 5'd1;
  localparam logic [4:0] K_KEYWORD   = 5'd2;
  localparam logic [4:0] K_TRUE      = 5'd3;
  localparam logic [4:0] K_FALSE     = 5'd4;
  localparam logic [4:0] K_NIL       = 5'd5;
  localparam logic [4:0] K_INT       = 5'd6;
  localparam logic [4:0] K_FLOAT     = 5'd7;
  localparam logic [4:0] K_STRING    = 5'd8;
  localparam logic [4:0] K_CHAR      = 5'd9;
  localparam logic [4:0] K_SYMBOL    = 5'd10;
  localparam logic [4:0] K_HASHPAREN = 5'd11;
  localparam logic [4:0] K_LPAREN    = 5'd12;
  localparam logic [4:0] K_RPAREN    = 5'd13;
  localparam logic [4:0] K_LBRACK    = 5'd14;
  localparam logic [4:0] K_RBRACK    = 5'd15;
  localparam logic [4:0] K_LBRACE    = 5'd16;
  localparam logic [4:0] K_RBRACE    = 5'd17;
  localparam logic [4:0] K_PERIOD    = 5'd18;
  localparam logic [4:0] K_SEMI      = 5'd19;
  localparam logic [4:0] K_CARET     = 5'd20;
  localparam logic [4:0] K_PIPE      = 5'd21;
  localparam logic [4:0] K_COLON     = 5'd22;
  localparam logic [4:0] K_ASSIGN    = 5'd23;
  localparam logic [4:0] K_GTGT      = 5'd24;
  localparam logic [4:0] K_BINOP     = 5'd25;
  localparam logic [4:0] K_ERROR     = 5'd26;
  localparam logic [4:0] K_NONE      = 5'd31;

  // binary operator codes
  localparam logic [4:0] OP_PLUS  = 5'd0;
  localparam logic [4:0] OP_STAR  = 5'd1;
  localparam logic [4:0] OP_SLASH = 5'd2;
  localparam logic [4:0] OP_AMP   = 5'd3;
  localparam logic [4:0] OP_COMMA = 5'd4;
  localparam logic [4:0] OP_AT    = 5'd5;
  localparam logic [4:0] OP_MINUS = 5'd6;
  localparam logic [4:0] OP_ARROW = 5'd7;
  localparam logic [4:0] OP_EQ    = 5'd8;
  localparam logic [4:0] OP_EQEQ  = 5'd9;
  localparam logic [4:0] OP_NE    = 5'd10;
  localparam logic [4:0] OP_NEQV  = 5'd11;
  localparam logic [4:0] OP_LT    = 5'd12;
  localparam logic [4:0] OP_LE    = 5'd13;
  localparam logic [4:0] OP_SHL   = 5'd14;
  localparam logic [4:0] OP_GT    = 5'd15;
  localparam logic [4:0] OP_GE    = 5'd16;
  localparam logic [4:0] OP_NONE  = 5'd17;

  // error codes
  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_STRING    = 3'd1;
  localparam logic [2:0] E_CHAR      = 3'd2;
  localparam logic [2:0] E_SYM_SHORT = 3'd3;
  localparam logic [2:0] E_SYM_BAD   = 3'd4;
  localparam logic [2:0] E_RANGE     = 3'd5;
  localparam logic [2:0] E_TILDE     = 3'd6;
  localparam logic [2:0] E_UNEXPECT  = 3'd7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic               record_type;
    logic [7:0]         text_byte;
    logic [4:0]         token_kind;
    logic [4:0]         operator_code;
    logic [15:0]        start_line;
    logic [15:0]        start_column;
    logic signed [63:0] integer_value;
    logic [2:0]         error_code;
    logic               last_of_run;
  } out_t;

  // all results of one source beat
  typedef struct packed {
    out_t [MaxResults-1:0] res;
    logic [CountBits-1:0]  count;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_name_start(logic [7:0] c);
    return is_alpha(c) || c == 8'h5f;
  endfunction

  function automatic logic is_name_char(logic [7:0] c);
    return is_name_start(c) || is_digit(c);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // + - * / = ~ < > & | @ ,
  function automatic logic is_bin_char(logic [7:0] c);
    return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h3d ||
           c == 8'h7e || c == 8'h3c || c == 8'h3e || c == 8'h26 || c == 8'h7c ||
           c == 8'h40 || c == 8'h2c;
  endfunction

  function automatic logic ends_operand(logic [4:0] k);
    return (k >= K_IDENT && k <= K_SYMBOL && k != K_KEYWORD) ||
           k == K_RPAREN || k == K_RBRACK || k == K_RBRACE;
  endfunction

  // drop reserved-word candidates that no longer match; bit 0 true, 1 false, 2 nil
  function automatic logic [2:0] word_match(logic [2:0] rw, logic [2:0] nl, logic [7:0] c);
    logic [7:0] t_ch;
    logic [7:0] f_ch;
    logic [7:0] n_ch;
    logic [2:0] r;
    case (nl)
      3'd0: begin t_ch = 8'h74; f_ch = 8'h66; n_ch = 8'h6e; end
      3'd1: begin t_ch = 8'h72; f_ch = 8'h61; n_ch = 8'h69; end
      3'd2: begin t_ch = 8'h75; f_ch = 8'h6c; n_ch = 8'h6c; end
      3'd3: begin t_ch = 8'h65; f_ch = 8'h73; n_ch = 8'h00; end
      3'd4: begin t_ch = 8'h00; f_ch = 8'h65; n_ch = 8'h00; end
      default: begin t_ch = 8'h00; f_ch = 8'h00; n_ch = 8'h00; end
    endcase
    r = rw;
    if (nl >= 3'd4 || t_ch != c) r[0] = 1'b0;
    if (nl >= 3'd5 || f_ch != c) r[1] = 1'b0;
    if (nl >= 3'd3 || n_ch != c) r[2] = 1'b0;
    return r;
  endfunction

  function automatic logic [4:0] name_kind(logic [2:0] rw, logic [2:0] nl);
    logic [4:0] k;
    k = K_IDENT;
    if (rw[0] && nl == 3'd4) k = K_TRUE;
    if (rw[1] && nl == 3'd5) k = K_FALSE;
    if (rw[2] && nl == 3'd3) k = K_NIL;
    return k;
  endfunction

endpackage

// File: rtl/sts_front.sv
// Front end of the token scanner: accepts source beats, runs the lexer state
// machine and emits all results of a beat as one bundle. Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_front #(
  parameter int POSITION_BITS = sts_pkg::PositionBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sts_pkg::in_t        in_data_i,
  input  sts_pkg::q_status_t  q_status_i,
  output logic                in_stall_o,
  output logic                push_o,
  output sts_pkg::bundle_t    bundle_o
);
  import sts_pkg::*;

  localparam int PB = POSITION_BITS;

  localparam logic [3:0] M_IDLE         = 4'd0;
  localparam logic [3:0] M_COMMENT      = 4'd1;
  localparam logic [3:0] M_NAME         = 4'd2;
  localparam logic [3:0] M_NAME_COLON   = 4'd3;
  localparam logic [3:0] M_NUMBER       = 4'd4;
  localparam logic [3:0] M_NUM_DOT      = 4'd5;
  localparam logic [3:0] M_FLOAT        = 4'd6;
  localparam logic [3:0] M_STRING       = 4'd7;
  localparam logic [3:0] M_STRING_QUOTE = 4'd8;
  localparam logic [3:0] M_CHAR         = 4'd9;
  localparam logic [3:0] M_HASH         = 4'd10;
  localparam logic [3:0] M_SYM_NAME     = 4'd11;
  localparam logic [3:0] M_SYM_COLON    = 4'd12;
  localparam logic [3:0] M_SYM_BIN      = 4'd13;
  localparam logic [3:0] M_OP           = 4'd14;

  localparam logic [PB-1:0] PosMax = {PB{1'b1}};
  localparam logic [PB-1:0] PosOne = PB'(1);

  logic [3:0]    mode_q, mode_d;
  logic [7:0]    pb_q, pb_d;
  logic [PB-1:0] pl_q, pl_d, pc_q, pc_d;
  logic [4:0]    pk_q, pk_d;
  logic          sp_q, sp_d;
  logic [PB-1:0] tl_q, tl_d, tc_q, tc_d;
  logic [63:0]   mag_q, mag_d;
  logic          ov_q, ov_d, neg_q, neg_d;
  logic [2:0]    rw_q, rw_d, nl_q, nl_d;
  logic [PB-1:0] line_q, line_d, col_q, col_d;

  logic          accept;
  logic [7:0]    c_in;
  logic          eof_in;
  logic [63:0]   dig;
  logic [63:0]   lim;
  logic [63:0]   cont_mag;
  logic          cont_ov;
  logic          fin_bad;
  logic [63:0]   fin_val;
  bundle_t       b;

  assign accept     = in_valid_i && !q_status_i.full;
  assign in_stall_o = q_status_i.full;
  assign c_in       = in_data_i.char_code;
  assign eof_in     = in_data_i.end_of_input;

  // digit append on the running magnitude with the signed range limit
  always_comb begin
    dig = {60'd0, c_in[3:0]};
    lim = (c_in[3:0] == 4'd9) ? 64'h0CCC_CCCC_CCCC_CCCB : 64'h0CCC_CCCC_CCCC_CCCC;
    cont_mag = mag_q;
    cont_ov  = ov_q;
    if (!ov_q) begin
      if (mag_q > lim) cont_ov = 1'b1;
      else cont_mag = (mag_q << 3) + (mag_q << 1) + dig;
    end
    fin_bad = ov_q || (!neg_q && mag_q[63]);
    fin_val = neg_q ? (64'd0 - mag_q) : mag_q;
  end

  // position of the next source byte
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (accept && !eof_in) begin
      if (c_in == 8'h0a) begin
        if (line_q < PosMax) line_d = line_q + PosOne;
        col_d = PosOne;
      end else if (col_q < PosMax) begin
        col_d = col_q + PosOne;
      end
    end
  end

  // lexer: up to three passes per beat (byte refed, held byte replayed)
  always_comb begin
    logic          go, h2, we, se;
    logic [7:0]    wc, sc;
    logic [PB-1:0] wl, wcol, sl, scol;
    logic          t_en, r_en;
    logic [7:0]    t_b;
    logic [4:0]    r_k, r_o;
    logic [63:0]   r_v;
    logic [2:0]    r_e;
    logic [2:0]    n;
    mode_d = mode_q; pb_d = pb_q; pl_d = pl_q; pc_d = pc_q;
    pk_d = pk_q; sp_d = sp_q; tl_d = tl_q; tc_d = tc_q;
    mag_d = mag_q; ov_d = ov_q; neg_d = neg_q; rw_d = rw_q; nl_d = nl_q;
    b = '0;
    n = '0;
    go = 1'b1; h2 = 1'b0;
    wc = c_in; wl = line_q; wcol = col_q; we = eof_in;
    sc = c_in; sl = line_q; scol = col_q; se = eof_in;
    for (int p = 0; p < 3; p++) begin
      t_en = 1'b0; t_b = wc; r_en = 1'b0; r_k = K_EOF; r_o = OP_NONE;
      r_v = 64'd0; r_e = E_NONE;
      if (go) begin
        go = 1'b0;
        if (we) begin
          // end of input: close the open token, then the end-of-file record
          case (mode_d)
            M_NAME: begin r_en = 1'b1; r_k = name_kind(rw_d, nl_d); go = 1'b1; end
            M_NAME_COLON: begin
              t_en = 1'b1; t_b = 8'h3a; r_en = 1'b1; r_k = K_KEYWORD; go = 1'b1;
            end
            M_NUMBER: begin
              r_en = 1'b1; r_k = fin_bad ? K_ERROR : K_INT;
              r_e = fin_bad ? E_RANGE : E_NONE; r_v = fin_bad ? 64'd0 : fin_val; go = 1'b1;
            end
            M_NUM_DOT: begin
              r_en = 1'b1; r_k = fin_bad ? K_ERROR : K_INT;
              r_e = fin_bad ? E_RANGE : E_NONE; r_v = fin_bad ? 64'd0 : fin_val;
              go = 1'b1; h2 = 1'b1; sc = wc; sl = wl; scol = wcol; se = we;
              wc = pb_d; wl = pl_d; wcol = pc_d; we = 1'b0;
            end
            M_FLOAT:        begin r_en = 1'b1; r_k = K_FLOAT; go = 1'b1; end
            M_STRING:       begin r_en = 1'b1; r_k = K_ERROR; r_e = E_STRING; go = 1'b1; end
            M_STRING_QUOTE: begin r_en = 1'b1; r_k = K_STRING; go = 1'b1; end
            M_CHAR:         begin r_en = 1'b1; r_k = K_ERROR; r_e = E_CHAR; go = 1'b1; end
            M_HASH: begin r_en = 1'b1; r_k = K_ERROR; r_e = E_SYM_SHORT; go = 1'b1; end
            M_SYM_NAME, M_SYM_BIN: begin r_en = 1'b1; r_k = K_SYMBOL; go = 1'b1; end
            M_SYM_COLON: begin
              t_en = 1'b1; t_b = 8'h3a; r_en = 1'b1; r_k = K_SYMBOL; go = 1'b1;
            end
            M_OP: begin
              r_en = 1'b1; go = 1'b1;
              case (pb_d)
                8'h2d: begin r_k = K_BINOP; r_o = OP_MINUS; end
                8'h3d: begin r_k = K_BINOP; r_o = OP_EQ; end
                8'h7e: begin r_k = K_ERROR; r_e = E_TILDE; end
                8'h3c: begin r_k = K_BINOP; r_o = OP_LT; end
                8'h3e: begin r_k = K_BINOP; r_o = OP_GT; end
                default: r_k = K_COLON;
              endcase
            end
            default: begin
              tl_d = line_q; tc_d = col_q; r_en = 1'b1; r_k = K_EOF;
            end
          endcase
          mode_d = M_IDLE;
        end else begin
          case (mode_d)
            M_COMMENT: if (wc == 8'h22) mode_d = M_IDLE;
            M_NAME: begin
              if (is_name_char(wc)) begin
                t_en = 1'b1; rw_d = word_match(rw_d, nl_d, wc);
                if (nl_d < 3'd7) nl_d = nl_d + 3'd1;
              end else if (wc == 8'h3a) begin
                pb_d = wc; pl_d = wl; pc_d = wcol; mode_d = M_NAME_COLON;
              end else begin
                r_en = 1'b1; r_k = name_kind(rw_d, nl_d); mode_d = M_IDLE; go = 1'b1;
              end
            end
            M_NAME_COLON: begin
              mode_d = M_IDLE;
              if (wc == 8'h3d) begin
                r_en = 1'b1; r_k = name_kind(rw_d, nl_d);
                go = 1'b1; h2 = 1'b1; sc = wc; sl = wl; scol = wcol; se = we;
                wc = pb_d; wl = pl_d; wcol = pc_d; we = 1'b0;
              end else begin
                t_en = 1'b1; t_b = 8'h3a; r_en = 1'b1; r_k = K_KEYWORD; go = 1'b1;
              end
            end
            M_NUMBER: begin
              if (is_digit(wc)) begin
                mag_d = cont_mag; ov_d = cont_ov;
              end else if (wc == 8'h2e) begin
                pb_d = wc; pl_d = wl; pc_d = wcol; mode_d = M_NUM_DOT;
              end else begin
                r_en = 1'b1; r_k = fin_bad ? K_ERROR : K_INT;
                r_e = fin_bad ? E_RANGE : E_NONE; r_v = fin_bad ? 64'd0 : fin_val;
                mode_d = M_IDLE; go = 1'b1;
              end
            end
            M_NUM_DOT: begin
              if (is_digit(wc)) begin
                mode_d = M_FLOAT;
              end else begin
                r_en = 1'b1; r_k = fin_bad ? K_ERROR : K_INT;
                r_e = fin_bad ? E_RANGE : E_NONE; r_v = fin_bad ? 64'd0 : fin_val;
                mode_d = M_IDLE;
                go = 1'b1; h2 = 1'b1; sc = wc; sl = wl; scol = wcol; se = we;
                wc = pb_d; wl = pl_d; wcol = pc_d; we = 1'b0;
              end
            end
            M_FLOAT: begin
              if (!is_digit(wc)) begin
                r_en = 1'b1; r_k = K_FLOAT; mode_d = M_IDLE; go = 1'b1;
              end
            end
            M_STRING: begin
              if (wc == 8'h27) begin
                pb_d = wc; pl_d = wl; pc_d = wcol; mode_d = M_STRING_QUOTE;
              end else begin
                t_en = 1'b1;
              end
            end
            M_STRING_QUOTE: begin
              if (wc == 8'h27) begin
                t_en = 1'b1; mode_d = M_STRING;
              end else begin
                r_en = 1'b1; r_k = K_STRING; mode_d = M_IDLE; go = 1'b1;
              end
            end
            M_CHAR: begin
              t_en = 1'b1; r_en = 1'b1; r_k = K_CHAR; mode_d = M_IDLE;
            end
            M_HASH: begin
              if (wc == 8'h28) begin
                r_en = 1'b1; r_k = K_HASHPAREN; mode_d = M_IDLE;
              end else if (is_name_start(wc)) begin
                t_en = 1'b1; mode_d = M_SYM_NAME;
              end else if (is_bin_char(wc)) begin
                t_en = 1'b1; mode_d = M_SYM_BIN;
              end else begin
                r_en = 1'b1; r_k = K_ERROR; r_e = E_SYM_BAD; mode_d = M_IDLE; go = 1'b1;
              end
            end
            M_SYM_NAME: begin
              if (is_name_char(wc)) begin
                t_en = 1'b1;
              end else if (wc == 8'h3a) begin
                pb_d = wc; pl_d = wl; pc_d = wcol; mode_d = M_SYM_COLON;
              end else begin
                r_en = 1'b1; r_k = K_SYMBOL; mode_d = M_IDLE; go = 1'b1;
              end
            end
            M_SYM_COLON: begin
              if (wc == 8'h3d) begin
                r_en = 1'b1; r_k = K_SYMBOL; mode_d = M_IDLE;
                go = 1'b1; h2 = 1'b1; sc = wc; sl = wl; scol = wcol; se = we;
                wc = pb_d; wl = pl_d; wcol = pc_d; we = 1'b0;
              end else begin
                t_en = 1'b1; t_b = 8'h3a; mode_d = M_SYM_NAME; go = 1'b1;
              end
            end
            M_SYM_BIN: begin
              mode_d = M_IDLE; r_en = 1'b1; r_k = K_SYMBOL;
              if (is_bin_char(wc)) t_en = 1'b1;
              else go = 1'b1;
            end
            M_OP: begin
              // two-byte operators and the sign of a negative literal
              mode_d = M_IDLE; r_en = 1'b1; r_k = K_BINOP;
              if (pb_d == 8'h2d && wc == 8'h3e) r_o = OP_ARROW;
              else if (pb_d == 8'h2d && is_digit(wc) &&
                       (!ends_operand(pk_d) || sp_d)) begin
                r_en = 1'b0; mode_d = M_NUMBER; neg_d = 1'b1; mag_d = dig; ov_d = 1'b0;
              end
              else if (pb_d == 8'h3d && wc == 8'h3d) r_o = OP_EQEQ;
              else if (pb_d == 8'h7e && wc == 8'h3d) r_o = OP_NE;
              else if (pb_d == 8'h7e && wc == 8'h7e) r_o = OP_NEQV;
              else if (pb_d == 8'h3c && wc == 8'h3d) r_o = OP_LE;
              else if (pb_d == 8'h3c && wc == 8'h3c) r_o = OP_SHL;
              else if (pb_d == 8'h3e && wc == 8'h3d) r_o = OP_GE;
              else if (pb_d == 8'h3e && wc == 8'h3e) r_k = K_GTGT;
              else if (pb_d == 8'h3a && wc == 8'h3d) r_k = K_ASSIGN;
              else begin
                go = 1'b1;
                case (pb_d)
                  8'h2d: r_o = OP_MINUS;
                  8'h3d: r_o = OP_EQ;
                  8'h7e: begin r_k = K_ERROR; r_e = E_TILDE; end
                  8'h3c: r_o = OP_LT;
                  8'h3e: r_o = OP_GT;
                  default: r_k = K_COLON;
                endcase
              end
            end
            default: begin
              // between tokens
              mode_d = M_IDLE;
              if (is_space(wc)) begin
                sp_d = 1'b1;
              end else if (wc == 8'h22) begin
                sp_d = 1'b1; mode_d = M_COMMENT;
              end else begin
                tl_d = wl; tc_d = wcol;
                if (is_name_start(wc)) begin
                  mode_d = M_NAME; t_en = 1'b1;
                  rw_d = word_match(3'b111, 3'd0, wc); nl_d = 3'd1;
                end else if (is_digit(wc)) begin
                  mode_d = M_NUMBER; neg_d = 1'b0; mag_d = dig; ov_d = 1'b0;
                end else begin
                  r_en = 1'b1;
                  case (wc)
                    8'h23: begin r_en = 1'b0; mode_d = M_HASH; end
                    8'h27: begin r_en = 1'b0; mode_d = M_STRING; end
                    8'h24: begin r_en = 1'b0; mode_d = M_CHAR; end
                    8'h28: r_k = K_LPAREN;
                    8'h29: r_k = K_RPAREN;
                    8'h5b: r_k = K_LBRACK;
                    8'h5d: r_k = K_RBRACK;
                    8'h7b: r_k = K_LBRACE;
                    8'h7d: r_k = K_RBRACE;
                    8'h2e: r_k = K_PERIOD;
                    8'h3b: r_k = K_SEMI;
                    8'h5e: r_k = K_CARET;
                    8'h7c: r_k = K_PIPE;
                    8'h2b: begin r_k = K_BINOP; r_o = OP_PLUS; end
                    8'h2a: begin r_k = K_BINOP; r_o = OP_STAR; end
                    8'h2f: begin r_k = K_BINOP; r_o = OP_SLASH; end
                    8'h26: begin r_k = K_BINOP; r_o = OP_AMP; end
                    8'h2c: begin r_k = K_BINOP; r_o = OP_COMMA; end
                    8'h40: begin r_k = K_BINOP; r_o = OP_AT; end
                    8'h2d, 8'h3d, 8'h7e, 8'h3c, 8'h3e, 8'h3a: begin
                      r_en = 1'b0; pb_d = wc; pl_d = wl; pc_d = wcol; mode_d = M_OP;
                    end
                    default: begin r_k = K_ERROR; r_e = E_UNEXPECT; end
                  endcase
                end
              end
            end
          endcase
        end
      end
      // append this pass's text byte, then its record
      if (t_en) begin
        b.res[n] = '{record_type: 1'b0, text_byte: t_b, token_kind: K_EOF,
                     operator_code: OP_NONE, start_line: 16'(tl_d),
                     start_column: 16'(tc_d), integer_value: 64'sd0,
                     error_code: E_NONE, last_of_run: 1'b0};
        n = n + 3'd1;
      end
      if (r_en) begin
        b.res[n] = '{record_type: 1'b1, text_byte: 8'd0, token_kind: r_k,
                     operator_code: r_o, start_line: 16'(tl_d),
                     start_column: 16'(tc_d), integer_value: r_v,
                     error_code: r_e, last_of_run: 1'b0};
        n = n + 3'd1;
        pk_d = r_k;
        sp_d = 1'b0;
      end
      if (!go && h2) begin
        go = 1'b1; h2 = 1'b0; wc = sc; wl = sl; wcol = scol; we = se;
      end
    end
    b.count = n;
  end

  assign push_o   = accept && (b.count != '0);
  assign bundle_o = b;

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pb_q   <= 8'd0;
      pl_q   <= PosOne;
      pc_q   <= PosOne;
      pk_q   <= K_NONE;
      sp_q   <= 1'b0;
      tl_q   <= PosOne;
      tc_q   <= PosOne;
      mag_q  <= 64'd0;
      ov_q   <= 1'b0;
      neg_q  <= 1'b0;
      rw_q   <= 3'b111;
      nl_q   <= 3'd0;
      line_q <= PosOne;
      col_q  <= PosOne;
    end else if (accept) begin
      mode_q <= mode_d;
      pb_q   <= pb_d;
      pl_q   <= pl_d;
      pc_q   <= pc_d;
      pk_q   <= pk_d;
      sp_q   <= sp_d;
      tl_q   <= tl_d;
      tc_q   <= tc_d;
      mag_q  <= mag_d;
      ov_q   <= ov_d;
      neg_q  <= neg_d;
      rw_q   <= rw_d;
      nl_q   <= nl_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

endmodule

// File: rtl/sts_queue.sv
// Two-entry queue of result bundles between scanner front and output back end.
// Depends on sts_pkg for the bundle and status types.
`timescale 1ns / 1ps

module sts_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sts_pkg::bundle_t    bundle_i,
  input  logic                pop_i,
  output sts_pkg::bundle_t    head_o,
  output sts_pkg::q_status_t  status_o
);
  import sts_pkg::*;

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == 2'd0);
  assign status_o.full  = (cnt_q == 2'd2);
  assign head_o         = mem_q[rd_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

  // bundle storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= bundle_i;
  end

endmodule

// File: rtl/sts_back.sv
// Back end: walks the head bundle and hands results out one beat at a time
// through a registered output stage. Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sts_pkg::bundle_t    head_i,
  input  sts_pkg::q_status_t  q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sts_pkg::out_t       out_data_o
);
  import sts_pkg::*;

  logic [CountBits-1:0] idx_q, idx_d;
  logic                 vld_q;
  out_t                 out_q, out_d;
  logic                 load, take, last;

  // pick the next result when the output register frees up
  always_comb begin
    load  = !vld_q || !out_stall_i;
    take  = load && !q_status_i.empty;
    last  = (idx_q == head_i.count - CountBits'(1));
    pop_o = take && last;
    idx_d = idx_q;
    if (take) idx_d = last ? '0 : idx_q + CountBits'(1);
  end

  // selected result with its end-of-run flag
  always_comb begin
    out_d             = head_i.res[idx_q];
    out_d.last_of_run = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) vld_q <= !q_status_i.empty;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> head_i.count != '0)
    else $error("queued bundle holds no result");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> idx_q < head_i.count)
    else $error("result index beyond bundle");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status_i.empty |-> idx_q == '0)
    else $error("result index not rewound on empty queue");

endmodule

// File: rtl/smalltalk_token_scanner.sv
// Smalltalk token scanner top level: front lexer, bundle queue, output stage.
// Depends on sts_pkg, sts_front, sts_queue and sts_back.
`timescale 1ns / 1ps

// The scanner takes one source byte (or an end-of-input beat) per cycle while
// its two-entry bundle queue has room, and turns it in the same cycle into the
// zero to six results it causes (text bytes and token records). The back end
// sends those results out one per cycle while the output is not stalled, so
// throughput is set by the output port: a bundle stays queued until its last
// result is taken. A byte that gives no result (whitespace, comment, digits of
// a number) pushes no bundle. An accepted byte's first result is written into
// the bundle queue, then into the output register. Line and column counters
// are POSITION_BITS wide and saturate; the result fields carry their low 16 bits.
module smalltalk_token_scanner #(
  parameter int POSITION_BITS = sts_pkg::PositionBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sts_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sts_pkg::out_t  out_data_o
);
  import sts_pkg::*;

  logic       push, pop;
  bundle_t    bundle, head;
  q_status_t  q_status;

  sts_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  sts_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  sts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
